// ===== hdl/rtds_pkg.sv =====
package rtds_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEGACY_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_US    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_US     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd5;

    localparam logic [1:0] EV_TICK    = 2'd0;
    localparam logic [1:0] EV_REFRESH = 2'd1;
    localparam logic [1:0] EV_COLOR   = 2'd2;
    localparam logic [1:0] EV_DRAW    = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_DELAY = 2'd2;

    localparam logic [2:0] DM_NONE    = 3'd0;
    localparam logic [2:0] DM_REFRESH = 3'd1;
    localparam logic [2:0] DM_SKIP    = 3'd3;
    localparam logic [2:0] DM_PREDICT = 3'd4;

    localparam logic signed [3:0] SYNC_MODE_MAX = 4'sd4;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [9:0]  US_PER_MS      = 10'd1000;
    localparam int          DEFAULT_PERIOD = 16667;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] timestamp_us;
    } event_t;

    typedef struct packed {
        logic        draw_start;
        logic        refresh_hit;
        logic [31:0] pred_delay_us;
        logic [31:0] wait_us;
        logic [31:0] last_interval_us;
        logic [31:0] avg_interval_us;
        logic [31:0] ema_interval_us;
        logic [31:0] min_interval_us;
        logic [31:0] max_interval_us;
        logic [31:0] ival_count;
        logic [31:0] refresh_count;
        logic [31:0] color_count;
    } result_t;

    typedef struct packed {
        logic load;
        logic record;
        logic step;
        logic div_go;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic div_done;
    } status_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/rtds_stream_if.sv =====
interface rtds_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rtds_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rtds_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;

    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_reg <= diff[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;
endmodule

// ===== hdl/rtds_ctrl.sv =====
module rtds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rtds_pkg::status_t status,
    output rtds_pkg::cmd_t    cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RECORD   = 3'd1;
    localparam logic [2:0] S_SYNC     = 3'd2;
    localparam logic [2:0] S_DIV_GO   = 3'd3;
    localparam logic [2:0] S_DIV_WAIT = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RECORD;
                end
            end
            S_RECORD:
            begin
                cmd.record = 1'b1;
                state_next = S_SYNC;
            end
            S_SYNC:
            begin
                if (status.more)
                    cmd.step = 1'b1;
                else
                    state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
endmodule

// ===== hdl/rtds_dp.sv =====
module rtds_dp #(
    parameter int TIME_WIDTH     = 48,
    parameter int INTERVAL_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rtds_pkg::cmd_t                      cmd,
    output rtds_pkg::status_t                   status,
    input  rtds_pkg::event_t                    item,
    output rtds_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [rtds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int TW = TIME_WIDTH;
    localparam int IW = INTERVAL_WIDTH;
    localparam int WW = (TW > IW) ? TW : IW;
    localparam int PW = (IW > 32) ? IW : 32;

    // configuration
    logic signed [3:0] sync_mode_reg;
    logic              legacy_reg;
    logic [31:0]       phase_reg;
    logic [31:0]       lead_reg;
    logic [15:0]       skip_reg;
    logic [15:0]       timeout_reg;

    // current transaction
    logic [TW-1:0] ts_reg;
    logic [1:0]    kind_reg;
    logic          pending_reg;
    logic          start_reg;
    logic [25:0]   tmo_us_reg;

    // statistics
    logic [TW-1:0] prev_time_reg;
    logic          prev_valid_reg;
    logic [IW-1:0] last_iv_reg;
    logic [TW-1:0] sum_reg;
    logic [31:0]   tally_reg;
    logic [IW-1:0] ema_reg;
    logic [IW-1:0] min_reg;
    logic [IW-1:0] max_reg;
    logic [31:0]   refresh_reg;
    logic [31:0]   color_reg;

    // draw sync
    logic [1:0]    phase_st_reg;
    logic [2:0]    draw_mode_reg;
    logic [TW-1:0] request_reg;
    logic [TW-1:0] wait_start_reg;
    logic [TW-1:0] delay_len_reg;
    logic [15:0]   skips_reg;
    logic          hit_reg;
    logic [IW-1:0] pred_reg;

    rtds_pkg::result_t out_reg;

    logic [TW-1:0] quot;
    logic          div_done;

    // interval logic
    logic [TW-1:0] diff;
    logic [WW-1:0] diff_w;
    logic [IW-1:0] iv;
    logic [IW+2:0] ema_acc;
    logic [IW-1:0] ema_new;
    logic [TW-1:0] wait_diff;

    assign diff      = ts_reg - prev_time_reg;
    assign diff_w    = WW'(diff);
    assign iv        = (diff_w > WW'({IW{1'b1}})) ? {IW{1'b1}} : IW'(diff_w);
    assign ema_acc   = {ema_reg, 3'b000} - (IW+3)'(ema_reg) + (IW+3)'(iv);
    assign ema_new   = (ema_reg == '0) ? iv : ema_acc[IW+2:3];
    assign wait_diff = ts_reg - request_reg;

    // mode decode
    logic [2:0] mode_dec;
    always_comb
    begin
        if (sync_mode_reg < 4'sd0)
            mode_dec = legacy_reg ? rtds_pkg::DM_REFRESH : rtds_pkg::DM_NONE;
        else if (sync_mode_reg > rtds_pkg::SYNC_MODE_MAX)
            mode_dec = rtds_pkg::DM_NONE;
        else
            mode_dec = sync_mode_reg[2:0];
    end

    // one step of the wait/delay sequence
    logic [TW-1:0] elapsed;
    logic          tmo_hit;
    logic          wait_fire;
    logic          delay_fire;
    logic [15:0]   eff_skips;
    logic [IW-1:0] period;
    logic [PW-1:0] period_w;
    logic [PW-1:0] lead_w;
    logic [PW-1:0] pred_w;

    assign elapsed    = ts_reg - wait_start_reg;
    assign tmo_hit    = (elapsed >= TW'(tmo_us_reg));
    assign wait_fire  = (phase_st_reg == rtds_pkg::PH_WAIT) && (pending_reg || tmo_hit);
    assign delay_fire = (phase_st_reg == rtds_pkg::PH_DELAY) && (elapsed >= delay_len_reg);
    assign eff_skips  = (!pending_reg && tmo_us_reg == '0) ? 16'd0 : skips_reg;
    assign period     = (ema_reg != '0) ? ema_reg :
                        (last_iv_reg != '0) ? last_iv_reg : IW'(rtds_pkg::DEFAULT_PERIOD);
    assign period_w   = PW'(period);
    assign lead_w     = PW'(lead_reg);
    assign pred_w     = (period_w > lead_w) ? period_w - lead_w : '0;

    assign status.more     = !start_reg && (wait_fire || delay_fire);
    assign status.div_done = div_done;

    rtds_div #(
        .NW (TW),
        .DW (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (sum_reg),
        .divisor  (tally_reg),
        .quotient (quot),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mode_reg  <= '0;
            legacy_reg     <= 1'b0;
            phase_reg      <= '0;
            lead_reg       <= '0;
            skip_reg       <= '0;
            timeout_reg    <= rtds_pkg::TIMEOUT_RESET;
            prev_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
            last_iv_reg    <= '0;
            sum_reg        <= '0;
            tally_reg      <= '0;
            ema_reg        <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            refresh_reg    <= '0;
            color_reg      <= '0;
            phase_st_reg   <= rtds_pkg::PH_IDLE;
            draw_mode_reg  <= rtds_pkg::DM_NONE;
            request_reg    <= '0;
            wait_start_reg <= '0;
            delay_len_reg  <= '0;
            skips_reg      <= '0;
            hit_reg        <= 1'b0;
            pred_reg       <= '0;
            start_reg      <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rtds_pkg::REG_SYNC_MODE:   sync_mode_reg <= cfg_data[3:0];
                    rtds_pkg::REG_LEGACY_WAIT: legacy_reg    <= cfg_data[0];
                    rtds_pkg::REG_PHASE_US:    phase_reg     <= cfg_data;
                    rtds_pkg::REG_LEAD_US:     lead_reg      <= cfg_data;
                    rtds_pkg::REG_SKIP_COUNT:  skip_reg      <= cfg_data[15:0];
                    rtds_pkg::REG_TIMEOUT_MS:  timeout_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (cmd.load)
            begin
                start_reg   <= 1'b0;
                pending_reg <= (item.mode == rtds_pkg::EV_REFRESH);
            end

            if (cmd.record)
            begin
                if (kind_reg == rtds_pkg::EV_REFRESH)
                begin
                    refresh_reg    <= refresh_reg + 1'b1;
                    prev_time_reg  <= ts_reg;
                    prev_valid_reg <= 1'b1;
                    if (prev_valid_reg)
                    begin
                        last_iv_reg <= iv;
                        sum_reg     <= sum_reg + TW'(iv);
                        tally_reg   <= tally_reg + 1'b1;
                        if (min_reg == '0 || iv < min_reg)
                            min_reg <= iv;
                        if (iv > max_reg)
                            max_reg <= iv;
                        ema_reg <= ema_new;
                    end
                end
                else if (kind_reg == rtds_pkg::EV_COLOR)
                begin
                    color_reg <= color_reg + 1'b1;
                end

                if (kind_reg == rtds_pkg::EV_DRAW && phase_st_reg == rtds_pkg::PH_IDLE)
                begin
                    draw_mode_reg <= mode_dec;
                    request_reg   <= ts_reg;
                    pred_reg      <= '0;
                    skips_reg     <= skip_reg;
                    if (mode_dec == rtds_pkg::DM_NONE)
                    begin
                        hit_reg   <= 1'b0;
                        start_reg <= 1'b1;
                    end
                    else
                    begin
                        hit_reg        <= 1'b1;
                        wait_start_reg <= ts_reg;
                        phase_st_reg   <= rtds_pkg::PH_WAIT;
                    end
                end
            end

            if (cmd.step)
            begin
                if (wait_fire)
                begin
                    pending_reg <= 1'b0;
                    if (!pending_reg)
                        hit_reg <= 1'b0;
                    skips_reg <= eff_skips;
                    if (draw_mode_reg == rtds_pkg::DM_SKIP && eff_skips != '0)
                    begin
                        skips_reg      <= eff_skips - 1'b1;
                        wait_start_reg <= ts_reg;
                    end
                    else if (draw_mode_reg == rtds_pkg::DM_REFRESH)
                    begin
                        phase_st_reg <= rtds_pkg::PH_IDLE;
                        start_reg    <= 1'b1;
                    end
                    else if (draw_mode_reg == rtds_pkg::DM_PREDICT)
                    begin
                        pred_reg       <= IW'(pred_w);
                        wait_start_reg <= ts_reg;
                        delay_len_reg  <= TW'(pred_w);
                        phase_st_reg   <= rtds_pkg::PH_DELAY;
                    end
                    else
                    begin
                        wait_start_reg <= ts_reg;
                        delay_len_reg  <= TW'(phase_reg);
                        phase_st_reg   <= rtds_pkg::PH_DELAY;
                    end
                end
                else
                begin
                    phase_st_reg <= rtds_pkg::PH_IDLE;
                    start_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ts_reg     <= TW'(item.timestamp_us);
            kind_reg   <= item.mode;
            tmo_us_reg <= 26'(timeout_reg) * 26'(rtds_pkg::US_PER_MS);
        end
        if (cmd.finish)
        begin
            out_reg.draw_start  <= start_reg;
            out_reg.refresh_hit <= start_reg && hit_reg;
            out_reg.pred_delay_us <=
                (start_reg && draw_mode_reg == rtds_pkg::DM_PREDICT) ?
                rtds_pkg::sat32(64'(pred_reg)) : 32'd0;
            out_reg.wait_us <= start_reg ?
                rtds_pkg::sat32(64'(wait_diff)) : 32'd0;
            out_reg.last_interval_us <= rtds_pkg::sat32(64'(last_iv_reg));
            out_reg.avg_interval_us  <= (tally_reg != '0) ?
                rtds_pkg::sat32(64'(quot)) : 32'd0;
            out_reg.ema_interval_us  <= rtds_pkg::sat32(64'(ema_reg));
            out_reg.min_interval_us  <= rtds_pkg::sat32(64'(min_reg));
            out_reg.max_interval_us  <= rtds_pkg::sat32(64'(max_reg));
            out_reg.ival_count       <= tally_reg;
            out_reg.refresh_count    <= refresh_reg;
            out_reg.color_count      <= color_reg;
        end
    end

    assign result = out_reg;
endmodule

// ===== hdl/refresh_tracked_draw_sync.sv =====
// Refresh-tracked draw synchronizer. Each event transaction (tick, refresh
// done, color done, draw request) yields exactly one result transaction that
// carries the draw-start decision and the current refresh interval statistics.
// One transaction is handled at a time: capture, statistics update, one wait
// or delay step for each such step that completes on this event (zero to
// three), then a bit-serial division of the interval sum by the count.
// Configuration writes are taken at any time but must be made while no
// transaction is in flight.
module refresh_tracked_draw_sync #(
    parameter int TIME_WIDTH     = 48,
    parameter int INTERVAL_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rtds_stream_if.sink                     events,
    rtds_stream_if.source                   results,
    input  logic                            cfg_we,
    input  logic [rtds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtds_pkg::CFG_DATA_W-1:0] cfg_data
);
    rtds_pkg::cmd_t    cmd;
    rtds_pkg::status_t status;

    rtds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rtds_dp #(
        .TIME_WIDTH     (TIME_WIDTH),
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (events.data),
        .result    (results.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule
